[rtl/core/bqmm_pkg.sv]
// Shared types and codes for the burst queue with running mean and median.
package bqmm_pkg;

   localparam int unsigned FIELD_W = 16;
   localparam int unsigned ENTRY_W = 32;
   localparam int unsigned MEAN_W  = 24;
   localparam int unsigned FRAC_W  = 8;

   typedef enum logic [1:0] {
      FUNC_PUSH  = 2'd0,
      FUNC_POP   = 2'd1,
      FUNC_SORT  = 2'd2,
      FUNC_QUERY = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic sort;
      logic [FIELD_W-1:0] proc_id;
      logic [FIELD_W-1:0] burst;
   } cmd_type;

   localparam int unsigned CMD_W = 3 + 2 * FIELD_W;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP_RD,
      ST_POP_UPD,
      ST_SO_RDI,
      ST_SO_GETV,
      ST_SO_RDJ,
      ST_SO_CMP,
      ST_SO_PUT,
      ST_REP,
      ST_HEAD,
      ST_DIV,
      ST_MD_RDO,
      ST_MD_GETO,
      ST_MD_RDI,
      ST_MD_ACC,
      ST_MD_CHK,
      ST_OUT
   } state_type;

endpackage

[rtl/core/bqmm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bqmm_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/bqmm_fifo.sv]
// Two-word queue that decouples producer and consumer.
module bqmm_fifo #(
   parameter int unsigned WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/bqmm_front.sv]
// Front end: accepts request words, decodes the operation and queues them.
module bqmm_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [1:0]             req_func,
   input  logic [bqmm_pkg::FIELD_W-1:0] req_proc_id,
   input  logic [bqmm_pkg::FIELD_W-1:0] req_burst,
   output logic                   cmd_valid,
   output bqmm_pkg::cmd_type      cmd,
   input  logic                   cmd_pop
);

   bqmm_pkg::cmd_type             dec;
   logic [bqmm_pkg::CMD_W-1:0]    cmd_bits;
   logic                          cmd_empty;

   always_comb begin
      dec         = '0;
      dec.proc_id = req_proc_id;
      dec.burst   = req_burst;
      unique case (bqmm_pkg::func_type'(req_func))
         bqmm_pkg::FUNC_PUSH:  dec.push = 1'b1;
         bqmm_pkg::FUNC_POP:   dec.pop  = 1'b1;
         bqmm_pkg::FUNC_SORT:  dec.sort = 1'b1;
         bqmm_pkg::FUNC_QUERY: dec.push = 1'b0;
         default:              dec.push = 1'b0;
      endcase
   end

   bqmm_fifo #(.WIDTH(bqmm_pkg::CMD_W)) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (dec),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_bits),
      .empty     (cmd_empty)
   );

   assign cmd       = bqmm_pkg::cmd_type'(cmd_bits);
   assign cmd_valid = !cmd_empty;

endmodule

[rtl/core/bqmm_back.sv]
// Back end: executes queue operations and computes head, mean and median.
module bqmm_back #(
   parameter int unsigned DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   input  bqmm_pkg::cmd_type                 cmd,
   output logic                              cmd_pop,
   input  logic                              rsp_full,
   output logic                              rsp_wr,
   output logic [75+$clog2(DEPTH+1)-1:0]     rsp_data
);

   localparam int unsigned AW   = $clog2(DEPTH);
   localparam int unsigned CW   = $clog2(DEPTH + 1);
   localparam int unsigned SUMW = bqmm_pkg::FIELD_W + CW;
   localparam int unsigned DW   = SUMW + bqmm_pkg::FRAC_W;
   localparam int unsigned DCW  = $clog2(DW + 1);
   localparam int unsigned FW   = bqmm_pkg::FIELD_W;
   localparam int unsigned EW   = bqmm_pkg::ENTRY_W;

   bqmm_pkg::state_type     state_ff, state_in;
   bqmm_pkg::cmd_type       cmd_ff, cmd_in;
   bqmm_pkg::status_type    status_ff, status_in;
   logic [AW-1:0]           head_ff, head_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [SUMW-1:0]         sum_ff, sum_in;
   logic [AW-1:0]           i_ff, i_in;
   logic [AW-1:0]           j_ff, j_in;
   logic [EW-1:0]           v_ff, v_in;
   logic [FW-1:0]           hid_ff, hid_in;
   logic [FW-1:0]           hb_ff, hb_in;
   logic [DW-1:0]           div_ff, div_in;
   logic [CW-1:0]           rem_ff, rem_in;
   logic [DCW-1:0]          dcnt_ff, dcnt_in;
   logic [FW-1:0]           cand_ff, cand_in;
   logic [CW-1:0]           lt_ff, lt_in;
   logic [CW-1:0]           eq_ff, eq_in;
   logic [FW-1:0]           med_ff, med_in;

   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [EW-1:0]           wr_data;
   logic [AW-1:0]           rd_addr;
   logic [EW-1:0]           rd_data;
   logic [FW-1:0]           rd_burst;

   logic                    is_full;
   logic                    is_zero;
   logic                    sort_gt;
   logic                    sort_last;
   logic                    md_last;
   logic                    md_hit;
   logic [CW-1:0]           mid_rank;
   logic [CW:0]             lt_eq_sum;
   logic [CW:0]             rem_sh;
   logic                    div_ge;

   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head, input logic [AW-1:0] pos);
      logic [AW:0] s;
      s = {1'b0, head} + {1'b0, pos};
      if (s >= (AW+1)'(DEPTH)) begin
         s = s - (AW+1)'(DEPTH);
      end
      return s[AW-1:0];
   endfunction

   bqmm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_burst  = rd_data[EW-1:FW];
   assign is_full   = (count_ff == CW'(DEPTH));
   assign is_zero   = (count_ff == '0);
   assign sort_gt   = (rd_burst > v_ff[EW-1:FW]);
   assign sort_last = ((CW'(i_ff) + CW'(1)) == count_ff);
   assign md_last   = ((CW'(j_ff) + CW'(1)) == count_ff);
   assign mid_rank  = count_ff >> 1;
   assign lt_eq_sum = {1'b0, lt_ff} + {1'b0, eq_ff};
   assign md_hit    = (lt_ff <= mid_rank) && ({1'b0, mid_rank} < lt_eq_sum);
   assign rem_sh    = {rem_ff, div_ff[DW-1]};
   assign div_ge    = (rem_sh >= {1'b0, count_ff});

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bqmm_pkg::ST_IDLE: begin
            if (cmd_valid) state_in = bqmm_pkg::ST_EXEC;
         end
         bqmm_pkg::ST_EXEC: begin
            priority if (cmd_ff.pop && !is_zero) begin
               state_in = bqmm_pkg::ST_POP_RD;
            end else if (cmd_ff.sort && (count_ff > CW'(1))) begin
               state_in = bqmm_pkg::ST_SO_RDI;
            end else begin
               state_in = bqmm_pkg::ST_REP;
            end
         end
         bqmm_pkg::ST_POP_RD:  state_in = bqmm_pkg::ST_POP_UPD;
         bqmm_pkg::ST_POP_UPD: state_in = bqmm_pkg::ST_REP;
         bqmm_pkg::ST_SO_RDI:  state_in = bqmm_pkg::ST_SO_GETV;
         bqmm_pkg::ST_SO_GETV: state_in = bqmm_pkg::ST_SO_RDJ;
         bqmm_pkg::ST_SO_RDJ:  state_in = bqmm_pkg::ST_SO_CMP;
         bqmm_pkg::ST_SO_CMP: begin
            if (sort_gt && (j_ff != AW'(1))) state_in = bqmm_pkg::ST_SO_RDJ;
            else state_in = bqmm_pkg::ST_SO_PUT;
         end
         bqmm_pkg::ST_SO_PUT: begin
            if (sort_last) state_in = bqmm_pkg::ST_REP;
            else state_in = bqmm_pkg::ST_SO_RDI;
         end
         bqmm_pkg::ST_REP: begin
            if (is_zero) state_in = bqmm_pkg::ST_OUT;
            else state_in = bqmm_pkg::ST_HEAD;
         end
         bqmm_pkg::ST_HEAD: state_in = bqmm_pkg::ST_DIV;
         bqmm_pkg::ST_DIV: begin
            if (dcnt_ff == DCW'(1)) state_in = bqmm_pkg::ST_MD_RDO;
         end
         bqmm_pkg::ST_MD_RDO:  state_in = bqmm_pkg::ST_MD_GETO;
         bqmm_pkg::ST_MD_GETO: state_in = bqmm_pkg::ST_MD_RDI;
         bqmm_pkg::ST_MD_RDI:  state_in = bqmm_pkg::ST_MD_ACC;
         bqmm_pkg::ST_MD_ACC: begin
            if (md_last) state_in = bqmm_pkg::ST_MD_CHK;
            else state_in = bqmm_pkg::ST_MD_RDI;
         end
         bqmm_pkg::ST_MD_CHK: begin
            if (md_hit) state_in = bqmm_pkg::ST_OUT;
            else state_in = bqmm_pkg::ST_MD_RDO;
         end
         bqmm_pkg::ST_OUT: begin
            if (!rsp_full) state_in = bqmm_pkg::ST_IDLE;
         end
         default: state_in = bqmm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_in    = cmd_ff;
      status_in = status_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      v_in      = v_ff;
      hid_in    = hid_ff;
      hb_in     = hb_ff;
      div_in    = div_ff;
      rem_in    = rem_ff;
      dcnt_in   = dcnt_ff;
      cand_in   = cand_ff;
      lt_in     = lt_ff;
      eq_in     = eq_ff;
      med_in    = med_ff;
      cmd_pop   = 1'b0;
      rsp_wr    = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = slot_of(head_ff, j_ff);
      wr_data   = rd_data;
      rd_addr   = head_ff;
      unique case (state_ff)
         bqmm_pkg::ST_IDLE: begin
            cmd_pop = cmd_valid;
            cmd_in  = cmd;
         end
         bqmm_pkg::ST_EXEC: begin
            status_in = bqmm_pkg::STAT_OK;
            i_in      = AW'(1);
            if (cmd_ff.push) begin
               if (is_full) begin
                  status_in = bqmm_pkg::STAT_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = slot_of(head_ff, count_ff[AW-1:0]);
                  wr_data  = {cmd_ff.burst, cmd_ff.proc_id};
                  count_in = count_ff + CW'(1);
                  sum_in   = sum_ff + SUMW'(cmd_ff.burst);
               end
            end
            if (cmd_ff.pop && is_zero) begin
               status_in = bqmm_pkg::STAT_EMPTY;
            end
         end
         bqmm_pkg::ST_POP_RD: rd_addr = head_ff;
         bqmm_pkg::ST_POP_UPD: begin
            sum_in   = sum_ff - SUMW'(rd_burst);
            head_in  = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
            count_in = count_ff - CW'(1);
         end
         bqmm_pkg::ST_SO_RDI: rd_addr = slot_of(head_ff, i_ff);
         bqmm_pkg::ST_SO_GETV: begin
            v_in = rd_data;
            j_in = i_ff;
         end
         bqmm_pkg::ST_SO_RDJ: rd_addr = slot_of(head_ff, j_ff - AW'(1));
         bqmm_pkg::ST_SO_CMP: begin
            if (sort_gt) begin
               wr_en   = 1'b1;
               wr_addr = slot_of(head_ff, j_ff);
               wr_data = rd_data;
               j_in    = j_ff - AW'(1);
            end
         end
         bqmm_pkg::ST_SO_PUT: begin
            wr_en   = 1'b1;
            wr_addr = slot_of(head_ff, j_ff);
            wr_data = v_ff;
            i_in    = i_ff + AW'(1);
         end
         bqmm_pkg::ST_REP: rd_addr = head_ff;
         bqmm_pkg::ST_HEAD: begin
            hid_in  = rd_data[FW-1:0];
            hb_in   = rd_burst;
            div_in  = {sum_ff, {bqmm_pkg::FRAC_W{1'b0}}};
            rem_in  = '0;
            dcnt_in = DCW'(DW);
            i_in    = '0;
         end
         bqmm_pkg::ST_DIV: begin
            rem_in  = div_ge ? rem_sh[CW-1:0] - count_ff : rem_sh[CW-1:0];
            div_in  = {div_ff[DW-2:0], div_ge};
            dcnt_in = dcnt_ff - DCW'(1);
         end
         bqmm_pkg::ST_MD_RDO: rd_addr = slot_of(head_ff, i_ff);
         bqmm_pkg::ST_MD_GETO: begin
            cand_in = rd_burst;
            lt_in   = '0;
            eq_in   = '0;
            j_in    = '0;
         end
         bqmm_pkg::ST_MD_RDI: rd_addr = slot_of(head_ff, j_ff);
         bqmm_pkg::ST_MD_ACC: begin
            lt_in = lt_ff + CW'(rd_burst < cand_ff);
            eq_in = eq_ff + CW'(rd_burst == cand_ff);
            j_in  = j_ff + AW'(1);
         end
         bqmm_pkg::ST_MD_CHK: begin
            med_in = cand_ff;
            i_in   = i_ff + AW'(1);
         end
         bqmm_pkg::ST_OUT: rsp_wr = !rsp_full;
         default: cmd_pop = 1'b0;
      endcase
   end

   always_comb begin
      if (is_zero) begin
         rsp_data = {{(2*FW){1'b0}}, count_ff, 1'b1,
                     {bqmm_pkg::MEAN_W{1'b0}}, {FW{1'b0}}, status_ff};
      end else begin
         rsp_data = {hid_ff, hb_ff, count_ff, 1'b0,
                     div_ff[bqmm_pkg::MEAN_W-1:0], med_ff, status_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bqmm_pkg::ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      status_ff <= status_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      v_ff      <= v_in;
      hid_ff    <= hid_in;
      hb_ff     <= hb_in;
      div_ff    <= div_in;
      rem_ff    <= rem_in;
      dcnt_ff   <= dcnt_in;
      cand_ff   <= cand_in;
      lt_ff     <= lt_in;
      eq_ff     <= eq_in;
      med_ff    <= med_in;
   end

endmodule

[rtl/core/burst_queue_mean_median.sv]
// Burst queue top level: request queue, execution engine and result queue.
// Execution time is set by the entry store, which has a single read port: the median scan
// reads every entry once per candidate, and the divider works serially through DW =
// 24+clog2(DEPTH+1) quotient bits. One word is in execution at a time.
// Reset clears control and counts; the entry store is not cleared.
module burst_queue_mean_median #(
   parameter int unsigned DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [1:0]                   req_func,
   input  logic [15:0]                  req_proc_id,
   input  logic [15:0]                  req_burst,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [15:0]                  rsp_head_id,
   output logic [15:0]                  rsp_head_burst,
   output logic [$clog2(DEPTH+1)-1:0]   rsp_waiting,
   output logic                         rsp_is_empty,
   output logic [23:0]                  rsp_mean_burst,
   output logic [15:0]                  rsp_median_burst,
   output logic [1:0]                   rsp_status
);

   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned RW = 75 + CW;

   logic               cmd_valid;
   bqmm_pkg::cmd_type  cmd;
   logic               cmd_pop;
   logic               rsp_full;
   logic               rsp_wr;
   logic [RW-1:0]      rsp_in_data;
   logic [RW-1:0]      rsp_out_data;

   bqmm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_func    (req_func),
      .req_proc_id (req_proc_id),
      .req_burst   (req_burst),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   bqmm_back #(.DEPTH(DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_wr    (rsp_wr),
      .rsp_data  (rsp_in_data)
   );

   bqmm_fifo #(.WIDTH(RW)) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_wr),
      .push_data (rsp_in_data),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_out_data),
      .empty     (rsp_empty)
   );

   assign rsp_head_id      = rsp_out_data[RW-1 -: 16];
   assign rsp_head_burst   = rsp_out_data[RW-17 -: 16];
   assign rsp_waiting      = rsp_out_data[RW-33 -: CW];
   assign rsp_is_empty     = rsp_out_data[42];
   assign rsp_mean_burst   = rsp_out_data[41:18];
   assign rsp_median_burst = rsp_out_data[17:2];
   assign rsp_status       = rsp_out_data[1:0];

endmodule

[bench/burst_queue_mean_median_tb.sv]
// Self-checking bench for the burst queue with running mean and median.
`timescale 1ns / 100ps

module burst_queue_mean_median_tb;

   localparam int unsigned DEPTH = 64;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   typedef struct {
      logic [15:0]          head_id;
      logic [15:0]          head_burst;
      logic [CNT_W-1:0]     waiting;
      logic                 is_empty;
      logic [23:0]          mean;
      logic [15:0]          median;
      bqmm_pkg::status_type status;
   } summary_type;

   typedef struct {
      bqmm_pkg::func_type func;
      logic [15:0]        proc_id;
      logic [15:0]        burst;
      bit                 typed;
      summary_type        want;
   } row_type;

   logic                clock;
   logic                reset;
   logic                req_push;
   logic                req_full;
   logic [1:0]          req_func;
   logic [15:0]         req_proc_id;
   logic [15:0]         req_burst;
   logic                rsp_empty;
   logic                rsp_pop;
   logic [15:0]         rsp_head_id;
   logic [15:0]         rsp_head_burst;
   logic [CNT_W-1:0]    rsp_waiting;
   logic                rsp_is_empty;
   logic [23:0]         rsp_mean_burst;
   logic [15:0]         rsp_median_burst;
   logic [1:0]          rsp_status;

   burst_queue_mean_median #(.DEPTH(DEPTH)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_func         (req_func),
      .req_proc_id      (req_proc_id),
      .req_burst        (req_burst),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_head_id      (rsp_head_id),
      .rsp_head_burst   (rsp_head_burst),
      .rsp_waiting      (rsp_waiting),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_mean_burst   (rsp_mean_burst),
      .rsp_median_burst (rsp_median_burst),
      .rsp_status       (rsp_status)
   );

   logic [15:0] held_id[$];
   logic [15:0] held_burst[$];
   longint unsigned burst_total;
   summary_type due_q[$];
   row_type     plan[$];
   int unsigned errors, words_sent, words_seen;
   int unsigned n_full, n_empty, n_sort, max_held;
   bit          quiet;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("burst_queue_mean_median regression: fail");
      $finish;
   end

   function automatic void stable_sort(ref logic [15:0] ids[$], ref logic [15:0] bs[$]);
      int j;
      logic [15:0] vi, vb;
      for (int i = 1; i < bs.size(); i++) begin
         vi = ids[i];
         vb = bs[i];
         j = i;
         while (j > 0 && bs[j-1] > vb) begin
            ids[j] = ids[j-1];
            bs[j] = bs[j-1];
            j--;
         end
         ids[j] = vi;
         bs[j] = vb;
      end
   endfunction

   function automatic summary_type apply_func(bqmm_pkg::func_type f, logic [15:0] id,
                                              logic [15:0] b);
      summary_type s;
      logic [15:0] ids[$];
      logic [15:0] bs[$];
      longint unsigned n;
      s.status = bqmm_pkg::STAT_OK;
      case (f)
         bqmm_pkg::FUNC_PUSH: begin
            if (held_burst.size() >= DEPTH) begin
               s.status = bqmm_pkg::STAT_FULL;
            end else begin
               held_id.insert(held_id.size(), id);
               held_burst.insert(held_burst.size(), b);
               burst_total += b;
            end
         end
         bqmm_pkg::FUNC_POP: begin
            if (held_burst.size() == 0) begin
               s.status = bqmm_pkg::STAT_EMPTY;
            end else begin
               burst_total -= held_burst.pop_front();
               void'(held_id.pop_front());
            end
         end
         bqmm_pkg::FUNC_SORT: stable_sort(held_id, held_burst);
         default: ;
      endcase
      n = held_burst.size();
      if (n == 0) begin
         s.head_id = '0;
         s.head_burst = '0;
         s.waiting = '0;
         s.is_empty = 1'b1;
         s.mean = '0;
         s.median = '0;
      end else begin
         ids = held_id;
         bs = held_burst;
         stable_sort(ids, bs);
         s.head_id = held_id[0];
         s.head_burst = held_burst[0];
         s.waiting = CNT_W'(n);
         s.is_empty = 1'b0;
         s.mean = 24'((burst_total << 8) / n);
         s.median = bs[n / 2];
      end
      return s;
   endfunction

   task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
      $display("%0t: word %0d %s expected 0x%0h got 0x%0h", $realtime, words_seen, what,
               want, got);
      errors++;
   endtask

   // call at a rising edge; returns once the edge has taken the word
   task automatic send_word(bqmm_pkg::func_type f, logic [15:0] id, logic [15:0] b,
                            bit typed, summary_type want);
      summary_type s;
      req_push <= 1'b1;
      req_func <= f;
      req_proc_id <= id;
      req_burst <= b;
      forever begin
         @(negedge clock);
         if (!req_full) break;
      end
      s = apply_func(f, id, b);
      due_q.insert(due_q.size(), typed ? want : s);
      words_sent++;
      if (held_burst.size() > max_held) max_held = held_burst.size();
      if (s.status == bqmm_pkg::STAT_FULL) n_full++;
      if (s.status == bqmm_pkg::STAT_EMPTY) n_empty++;
      if (f == bqmm_pkg::FUNC_SORT) n_sort++;
      @(posedge clock);
      if (!quiet && $urandom_range(99) < 12) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      while (due_q.size() != 0) @(posedge clock);
   endtask

   task automatic add_row(bqmm_pkg::func_type f, logic [15:0] id, logic [15:0] b, bit typed,
                          logic [15:0] hid, logic [15:0] hb, int w, logic [23:0] m,
                          logic [15:0] md, bqmm_pkg::status_type st);
      row_type r;
      r.func = f;
      r.proc_id = id;
      r.burst = b;
      r.typed = typed;
      r.want.head_id = hid;
      r.want.head_burst = hb;
      r.want.waiting = CNT_W'(w);
      r.want.is_empty = (w == 0);
      r.want.mean = m;
      r.want.median = md;
      r.want.status = st;
      plan.insert(plan.size(), r);
   endtask

   initial begin
      rsp_pop = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         rsp_pop <= (quiet || $urandom_range(99) >= 12);
         @(posedge clock);
      end
   end

   always @(negedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (due_q.size() == 0) begin
            $display("%0t: result word with nothing pending", $realtime);
            errors++;
         end else begin
            summary_type w;
            w = due_q.pop_front();
            if (rsp_head_id !== w.head_id) report_mismatch("head_id", w.head_id, rsp_head_id);
            if (rsp_head_burst !== w.head_burst)
               report_mismatch("head_burst", w.head_burst, rsp_head_burst);
            if (rsp_waiting !== w.waiting) report_mismatch("waiting", w.waiting, rsp_waiting);
            if (rsp_is_empty !== w.is_empty)
               report_mismatch("is_empty", w.is_empty, rsp_is_empty);
            if (rsp_mean_burst !== w.mean) report_mismatch("mean_burst", w.mean, rsp_mean_burst);
            if (rsp_median_burst !== w.median)
               report_mismatch("median_burst", w.median, rsp_median_burst);
            if (rsp_status !== w.status) report_mismatch("status", w.status, rsp_status);
         end
         words_seen++;
      end
   end

   initial begin
      summary_type none;
      bqmm_pkg::func_type f;
      int unsigned r, cnt, waited;
      logic [15:0] b;
      reset = 1'b1;
      req_push = 1'b0;
      req_func = bqmm_pkg::FUNC_QUERY;
      req_proc_id = '0;
      req_burst = '0;
      burst_total = 0;
      quiet = 1'b0;
      none = '{default: '0, status: bqmm_pkg::STAT_OK};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      add_row(bqmm_pkg::FUNC_QUERY, 16'h1234, 16'h5678, 1, 0, 0, 0, 0, 0, bqmm_pkg::STAT_OK);
      add_row(bqmm_pkg::FUNC_POP, 16'hffff, 16'hffff, 1, 0, 0, 0, 0, 0,
              bqmm_pkg::STAT_EMPTY);
      add_row(bqmm_pkg::FUNC_SORT, 16'h0000, 16'h0000, 1, 0, 0, 0, 0, 0, bqmm_pkg::STAT_OK);
      add_row(bqmm_pkg::FUNC_PUSH, 16'hffff, 16'hffff, 1, 16'hffff, 16'hffff, 1, 24'hffff00,
              16'hffff, bqmm_pkg::STAT_OK);
      add_row(bqmm_pkg::FUNC_SORT, 16'h0000, 16'h0000, 1, 16'hffff, 16'hffff, 1, 24'hffff00,
              16'hffff, bqmm_pkg::STAT_OK);
      add_row(bqmm_pkg::FUNC_POP,   16'h0000, 16'h0000, 1, 0, 0, 0, 0, 0, bqmm_pkg::STAT_OK);
      add_row(bqmm_pkg::FUNC_PUSH,  16'h0000, 16'h0000, 1, 0, 0, 1, 0, 0, bqmm_pkg::STAT_OK);
      add_row(bqmm_pkg::FUNC_PUSH,  16'h0001, 16'hffff, 0, 0, 0, 0, 0, 0, bqmm_pkg::STAT_OK);
      add_row(bqmm_pkg::FUNC_PUSH,  16'h0002, 16'h0005, 0, 0, 0, 0, 0, 0, bqmm_pkg::STAT_OK);
      add_row(bqmm_pkg::FUNC_PUSH,  16'h0003, 16'h0005, 0, 0, 0, 0, 0, 0, bqmm_pkg::STAT_OK);
      add_row(bqmm_pkg::FUNC_PUSH,  16'h0004, 16'h0000, 0, 0, 0, 0, 0, 0, bqmm_pkg::STAT_OK);
      add_row(bqmm_pkg::FUNC_QUERY, 16'hffff, 16'hffff, 0, 0, 0, 0, 0, 0, bqmm_pkg::STAT_OK);
      add_row(bqmm_pkg::FUNC_SORT,  16'haaaa, 16'h5555, 0, 0, 0, 0, 0, 0, bqmm_pkg::STAT_OK);
      add_row(bqmm_pkg::FUNC_QUERY, 16'h5555, 16'haaaa, 0, 0, 0, 0, 0, 0, bqmm_pkg::STAT_OK);
      add_row(bqmm_pkg::FUNC_PUSH,  16'haaaa, 16'h8000, 0, 0, 0, 0, 0, 0, bqmm_pkg::STAT_OK);
      add_row(bqmm_pkg::FUNC_SORT,  16'h0000, 16'h0000, 0, 0, 0, 0, 0, 0, bqmm_pkg::STAT_OK);
      for (int i = 0; i < 6; i++)
         add_row(bqmm_pkg::FUNC_POP, 16'h0000, 16'h0000, 0, 0, 0, 0, 0, 0, bqmm_pkg::STAT_OK);
      add_row(bqmm_pkg::FUNC_POP, 16'h0000, 16'h0000, 1, 0, 0, 0, 0, 0,
              bqmm_pkg::STAT_EMPTY);

      foreach (plan[i])
         send_word(plan[i].func, plan[i].proc_id, plan[i].burst, plan[i].typed, plan[i].want);

      // hold the sender until the result queue runs dry
      drain_results();
      @(posedge clock);

      // fill to capacity, overflow, sort a full queue, then empty it
      for (int i = 0; i < DEPTH + 2; i++)
         send_word(bqmm_pkg::FUNC_PUSH, 16'($urandom), 16'($urandom_range(0, 9)), 0, none);
      send_word(bqmm_pkg::FUNC_SORT, 16'($urandom), 16'($urandom), 0, none);
      send_word(bqmm_pkg::FUNC_QUERY, 16'($urandom), 16'($urandom), 0, none);
      for (int i = 0; i < DEPTH; i++)
         send_word(bqmm_pkg::FUNC_POP, 16'($urandom), 16'($urandom), 0, none);

      for (int i = 0; i < 1150; i++) begin
         quiet = (i >= 400 && i < 650);
         cnt = held_burst.size();
         r = $urandom_range(99);
         if (r < ((cnt < 10) ? 50 : 20)) f = bqmm_pkg::FUNC_PUSH;
         else if (r < 80) f = bqmm_pkg::FUNC_POP;
         else if (r < 90) f = bqmm_pkg::FUNC_SORT;
         else f = bqmm_pkg::FUNC_QUERY;
         b = ($urandom_range(1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
         send_word(f, 16'($urandom), b, 0, none);
      end
      quiet = 1'b0;

      req_push <= 1'b0;
      waited = 0;
      while (due_q.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (200) @(posedge clock);
      $display("covered %0d words, %0d sorts, %0d full and %0d empty refusals, peak fill %0d",
               words_sent, n_sort, n_full, n_empty, max_held);
      $display("%0d result words checked, %0d mismatches, %0d left pending",
               words_seen, errors, due_q.size());
      if (errors == 0 && due_q.size() == 0) begin
         $display("burst_queue_mean_median regression: pass");
      end else begin
         $display("burst_queue_mean_median regression: fail");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/bqmm_pkg.sv
rtl/core/bqmm_ram.sv
rtl/core/bqmm_fifo.sv
rtl/core/bqmm_front.sv
rtl/core/bqmm_back.sv
rtl/core/burst_queue_mean_median.sv
bench/burst_queue_mean_median_tb.sv
